// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and defaults of the text console character writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int DEF_COLUMNS     = 80;
  localparam int DEF_ROWS        = 25;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 40;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] RESET_ATTR = 8'h0F;
  localparam int         TAB_STEP   = 8;

  typedef enum logic [2:0] {
    OP_NOP   = 3'd0,
    OP_PUT   = 3'd1,
    OP_NL    = 3'd2,
    OP_CR    = 3'd3,
    OP_TAB   = 3'd4,
    OP_BS    = 3'd5,
    OP_CLEAR = 3'd6,
    OP_READ  = 3'd7
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] chr;
    logic       rd_ok;
  } cmd_entry_t;

endpackage

// File: rtl/text_console_character_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_character_writer_unit
// Text console engine with a ROWS x COLUMNS store of attribute/character cells.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the command (put, clear, read), tdata the
// character and the row/column of a read. Output stream: one transaction per
// input with the cursor column, row and linear position and the cell read.
// Configuration: cfg_valid/cfg_data write the color attribute; cfg_ready is
// always high.
// A put, newline, tab, backspace, clear or unused command passes the operation
// queue and the result register; an in-range read passes the queue, the store's
// read register, S_RDWAIT and the result register. Plain operations sustain one
// transaction per cycle while the output is not stalled; an in-range read also
// holds the back end in S_RDWAIT. Scrolling keeps the back end busy after the
// result is issued (S_SCROLL, S_DRAIN, S_FILL), a clear in S_FILL; meanwhile
// the operation queue fills and s_axis_tready drops once it is full.
// Reset: the store is swept to spaces with attribute 0x0F, one cell a cycle,
// with s_axis_tready low. A stalled output holds its result; the back end
// stops and the queue absorbs up to QUEUE_DEPTH further transactions.
// ----------------------------------------------------------------------------
module text_console_character_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS     = DEF_COLUMNS,
  parameter int ROWS        = DEF_ROWS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // char_code, read_row, read_col
  input  logic [1:0]           s_axis_tuser,  // cmd
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // cursor_column, cursor_line, cursor_linear, cell_data
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  localparam int AW      = $clog2(COLUMNS * ROWS);
  localparam int ENTRY_W = $bits(cmd_entry_t);
  localparam int DATA_W  = ENTRY_W + AW;

  logic              init_busy;
  logic              push_valid;
  logic              push_ready;
  cmd_entry_t        push_entry;
  logic [AW-1:0]     push_addr;
  logic [DATA_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [DATA_W-1:0] pop_data;
  cmd_entry_t        pop_entry;
  logic [AW-1:0]     pop_addr;
  logic [6:0]        out_col;
  logic [4:0]        out_row;
  logic [10:0]       out_lin;
  logic [15:0]       out_cell;

  assign cfg_ready    = 1'b1;
  assign push_data    = {push_addr, push_entry};
  assign pop_entry    = cmd_entry_t'(pop_data[ENTRY_W-1:0]);
  assign pop_addr     = pop_data[DATA_W-1:ENTRY_W];
  assign m_axis_tdata = {1'b0, out_cell, out_lin, out_row, out_col};

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .init_busy     (init_busy),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_entry    (push_entry),
    .push_addr     (push_addr)
  );

  tcw_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W (DATA_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .pop_addr  (pop_addr),
    .init_busy (init_busy),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_col   (out_col),
    .out_row   (out_row),
    .out_lin   (out_lin),
    .out_cell  (out_cell)
  );

endmodule

// File: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Input side: accepts transactions, decodes them into operations and
// computes the cell address of reads.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int AW      = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // char_code, read_row, read_col
  input  logic [1:0]           s_axis_tuser,  // cmd
  input  logic                 init_busy,
  output logic                 push_valid,
  input  logic                 push_ready,
  output cmd_entry_t           push_entry,
  output logic [AW-1:0]        push_addr
);

  logic [7:0] char_code;
  logic [4:0] read_row;
  logic [6:0] read_col;
  logic [1:0] cmd;

  assign char_code = s_axis_tdata[7:0];
  assign read_row  = s_axis_tdata[12:8];
  assign read_col  = s_axis_tdata[19:13];
  assign cmd       = s_axis_tuser;

  assign s_axis_tready = push_ready && !init_busy;
  assign push_valid    = s_axis_tvalid && !init_busy;

  always_comb begin
    push_entry.chr   = char_code;
    push_entry.rd_ok = (7'(read_row) < 7'(ROWS)) && (8'(read_col) < 8'(COLUMNS));
    case (cmd)
      CMD_PUT: begin
        case (char_code)
          CH_LF:   push_entry.op = OP_NL;
          CH_CR:   push_entry.op = OP_CR;
          CH_TAB:  push_entry.op = OP_TAB;
          CH_BS:   push_entry.op = OP_BS;
          default: push_entry.op = OP_PUT;
        endcase
      end
      CMD_CLEAR: push_entry.op = OP_CLEAR;
      CMD_READ:  push_entry.op = OP_READ;
      default:   push_entry.op = OP_NOP;
    endcase
  end

  assign push_addr = AW'(AW'(read_row) * AW'(COLUMNS)) + AW'(read_col);

endmodule

// File: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Short FIFO of decoded operations between the front and the back.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; #(
  parameter int DEPTH  = DEF_QUEUE_DEPTH,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wptr;
  logic [PW-1:0]     rptr;
  logic [PW:0]       count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != (PW+1)'(DEPTH));
  assign pop_valid  = (count != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Execution side: cursor, screen store, scroll and fill sweeps, and the
// result register.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int AW      = $clog2(DEF_COLUMNS * DEF_ROWS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  input  logic [7:0]    cfg_data,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  cmd_entry_t    pop_entry,
  input  logic [AW-1:0] pop_addr,
  output logic          init_busy,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [6:0]    out_col,
  output logic [4:0]    out_row,
  output logic [10:0]   out_lin,
  output logic [15:0]   out_cell
);

  localparam int CELLS     = COLUMNS * ROWS;
  localparam int CW        = $clog2(COLUMNS);
  localparam int RW        = $clog2(ROWS);
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDWAIT = 5'b00010,
    S_SCROLL = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FILL   = 5'b10000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] col, col_next;
  logic [RW-1:0] row, row_next;
  logic [AW-1:0] row_base, row_base_next;
  logic [AW-1:0] sweep, sweep_next;
  logic [15:0]   fill_value, fill_value_next;
  logic          init, init_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr, pend_addr_next;
  logic [7:0]    attr;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_q;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;
  logic [AW-1:0] raddr;

  logic          start;
  logic          adv_row;
  logic          load_out;
  logic [15:0]   load_cell;
  logic [CW:0]   col_ext;
  logic [CW:0]   col_inc;
  logic [CW:0]   tab_sum;

  assign init_busy = init;
  assign start     = (state == S_IDLE) && pop_valid && (!out_valid || out_ready);
  assign col_ext   = {1'b0, col};
  assign col_inc   = col_ext + (CW+1)'(1);
  assign tab_sum   = (col_ext + (CW+1)'(TAB_STEP)) & ~((CW+1)'(TAB_STEP - 1));

  always_comb begin
    state_next      = state;
    col_next        = col;
    row_next        = row;
    row_base_next   = row_base;
    sweep_next      = sweep;
    fill_value_next = fill_value;
    init_next       = init;
    pend_next       = pend;
    pend_addr_next  = pend_addr;
    we              = 1'b0;
    waddr           = sweep;
    wdata           = fill_value;
    raddr           = pop_addr;
    pop_ready       = 1'b0;
    adv_row         = 1'b0;
    load_out        = 1'b0;
    load_cell       = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          pop_ready = 1'b1;
          load_out  = 1'b1;
          case (pop_entry.op)
            OP_PUT: begin
              we    = 1'b1;
              waddr = row_base + AW'(col);
              wdata = {attr, pop_entry.chr};
              if (col_inc >= (CW+1)'(COLUMNS)) begin
                adv_row = 1'b1;
              end else begin
                col_next = CW'(col_inc);
              end
            end
            OP_NL: adv_row = 1'b1;
            OP_CR: col_next = '0;
            OP_TAB: begin
              if (tab_sum >= (CW+1)'(COLUMNS)) begin
                adv_row = 1'b1;
              end else begin
                col_next = CW'(tab_sum);
              end
            end
            OP_BS: begin
              if (col != '0) begin
                col_next = col - CW'(1);
              end
            end
            OP_CLEAR: begin
              col_next        = '0;
              row_next        = '0;
              row_base_next   = '0;
              sweep_next      = '0;
              fill_value_next = {attr, CH_SPACE};
              state_next      = S_FILL;
            end
            OP_READ: begin
              if (pop_entry.rd_ok) begin
                load_out   = 1'b0;
                state_next = S_RDWAIT;
              end
            end
            OP_NOP: ;
            default: ;
          endcase
          if (adv_row) begin
            col_next = '0;
            if (row == RW'(ROWS - 1)) begin
              sweep_next      = '0;
              pend_next       = 1'b0;
              fill_value_next = {attr, CH_SPACE};
              state_next      = S_SCROLL;
            end else begin
              row_next      = row + RW'(1);
              row_base_next = row_base + AW'(COLUMNS);
            end
          end
        end
      end
      S_RDWAIT: begin
        load_out   = 1'b1;
        load_cell  = rd_q;
        state_next = S_IDLE;
      end
      S_SCROLL: begin
        raddr          = sweep + AW'(COLUMNS);
        we             = pend;
        waddr          = pend_addr;
        wdata          = rd_q;
        pend_next      = 1'b1;
        pend_addr_next = sweep;
        sweep_next     = sweep + AW'(1);
        if (sweep == AW'(LAST_BASE - 1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        we         = 1'b1;
        waddr      = pend_addr;
        wdata      = rd_q;
        pend_next  = 1'b0;
        state_next = S_FILL;
      end
      S_FILL: begin
        we         = 1'b1;
        waddr      = sweep;
        wdata      = fill_value;
        sweep_next = sweep + AW'(1);
        if (sweep == AW'(CELLS - 1)) begin
          init_next  = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      col        <= '0;
      row        <= '0;
      row_base   <= '0;
      sweep      <= '0;
      fill_value <= {RESET_ATTR, CH_SPACE};
      init       <= 1'b1;
      pend       <= 1'b0;
      pend_addr  <= '0;
      attr       <= RESET_ATTR;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      col        <= col_next;
      row        <= row_next;
      row_base   <= row_base_next;
      sweep      <= sweep_next;
      fill_value <= fill_value_next;
      init       <= init_next;
      pend       <= pend_next;
      pend_addr  <= pend_addr_next;
      if (cfg_valid) begin
        attr <= cfg_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_col  <= 7'(col_next);
      out_row  <= 5'(row_next);
      out_lin  <= 11'(row_base_next + AW'(col_next));
      out_cell <= load_cell;
    end
  end

endmodule

// File: rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level assertions for the text console character writer.
// ----------------------------------------------------------------------------
module tcw_checker import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  // cursor_column, cursor_line, cursor_linear, cell_data
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  a_init_blocks_input: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("input accepted right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (8'(m_axis_tdata[6:0]) < 8'(COLUMNS))
                   && ((ROWS > 32) || (7'(m_axis_tdata[11:7]) < 7'(ROWS))))
    else $error("cursor outside screen");

  a_linear_match: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (ROWS > 32) || (m_axis_tdata[22:12] ==
      11'(32'(m_axis_tdata[11:7]) * COLUMNS + 32'(m_axis_tdata[6:0]))))
    else $error("linear position disagrees with cursor");

endmodule

bind text_console_character_writer_unit tcw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tcw_checker (.*);

// File: test/console_cursor_checker.sv
// ----------------------------------------------------------------------------
// console_cursor_checker
// Watches the input, output and attribute channels of the text console writer,
// keeps its own screen store and cursor, and compares every output
// transaction field by field with the oldest expected cursor report.
// ----------------------------------------------------------------------------
module console_cursor_checker import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [7:0]           cfg_data,
  output int                   outstanding,
  output int                   fail_count
);

  typedef struct packed {
    logic [15:0] cell_data;
    logic [10:0] linear;
    logic [4:0]  line;
    logic [6:0]  column;
  } cursor_report_t;

  logic [15:0]    screen [ROWS*COLUMNS];
  int             cur_col;
  int             cur_row;
  logic [7:0]     attr;
  cursor_report_t report_q[$];

  function automatic void blank_screen();
    for (int i = 0; i < ROWS*COLUMNS; i++) screen[i] = {attr, CH_SPACE};
  endfunction

  function automatic void next_row();
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i < (ROWS-1)*COLUMNS; i++) screen[i] = screen[i+COLUMNS];
      for (int i = 0; i < COLUMNS; i++) screen[(ROWS-1)*COLUMNS+i] = {attr, CH_SPACE};
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic cursor_report_t apply_command(input logic [1:0] cmd,
                                                   input logic [7:0] ch,
                                                   input logic [4:0] rrow,
                                                   input logic [6:0] rcol);
    cursor_report_t res;
    int             lin;
    res.cell_data = '0;
    case (cmd)
      CMD_PUT: begin
        if (ch == CH_LF) begin
          next_row();
        end else if (ch == CH_CR) begin
          cur_col = 0;
        end else if (ch == CH_TAB) begin
          cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
          if (cur_col >= COLUMNS) next_row();
        end else if (ch == CH_BS) begin
          if (cur_col > 0) cur_col--;
        end else begin
          screen[cur_row*COLUMNS + cur_col] = {attr, ch};
          cur_col++;
          if (cur_col >= COLUMNS) next_row();
        end
      end
      CMD_CLEAR: begin
        blank_screen();
        cur_col = 0;
        cur_row = 0;
      end
      CMD_READ: begin
        if (rrow < ROWS && rcol < COLUMNS) res.cell_data = screen[rrow*COLUMNS + rcol];
      end
      default: ;
    endcase
    lin        = cur_row*COLUMNS + cur_col;
    res.column = cur_col[6:0];
    res.line   = cur_row[4:0];
    res.linear = lin[10:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    cursor_report_t got;
    cursor_report_t want;
    if (rst) begin
      attr    = RESET_ATTR;
      cur_col = 0;
      cur_row = 0;
      blank_screen();
      report_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) attr = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[38:0];
        if (report_q.size() == 0) begin
          report_mismatch($sformatf("result %h with nothing pending", m_axis_tdata));
        end else begin
          want = report_q.pop_front();
          if (got.column !== want.column)
            report_mismatch($sformatf("cursor_column %0d, want %0d", got.column, want.column));
          if (got.line !== want.line)
            report_mismatch($sformatf("cursor_line %0d, want %0d", got.line, want.line));
          if (got.linear !== want.linear)
            report_mismatch($sformatf("cursor_linear %0d, want %0d", got.linear, want.linear));
          if (got.cell_data !== want.cell_data)
            report_mismatch($sformatf("cell_data %h, want %h", got.cell_data,
                                      want.cell_data));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        report_q.push_back(apply_command(s_axis_tuser, s_axis_tdata[7:0],
                                         s_axis_tdata[12:8], s_axis_tdata[19:13]));
    end
    outstanding = report_q.size();
  end

endmodule

// File: test/tb_text_console_character_writer_unit.sv
// ----------------------------------------------------------------------------
// tb_text_console_character_writer_unit
// Drives the text console writer with directed puts, control codes, clears
// and cell reads, then with random phases under several color attributes,
// some of them heavy in newlines so the screen scrolls; random idle bursts on
// both streams. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_text_console_character_writer_unit import tcw_pkg::*;;

  localparam int         COLUMNS    = DEF_COLUMNS;
  localparam int         ROWS       = DEF_ROWS;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         SETTLE     = ROWS*COLUMNS + 100;
  localparam int         DRAIN      = 50;
  localparam int         LIMIT      = 20000000;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // char_code, read_row, read_col
  logic [1:0]           s_axis_tuser  = CMD_PUT;  // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  // cursor_column, cursor_line, cursor_linear, cell_data
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [7:0]           cfg_data      = '0;
  int                   outstanding;
  int                   fail_count;
  bit                   calm          = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_character_writer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  console_cursor_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .outstanding   (outstanding),
    .fail_count    (fail_count)
  );

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                           input logic [4:0] row, input logic [6:0] col);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'b0, col, row, ch};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int count, input bit scrolling);
    logic [1:0] cmd;
    logic [7:0] ch;
    logic [4:0] row;
    logic [6:0] col;
    int         r;
    int         k;
    int         lf_pct;
    lf_pct = scrolling ? 16 : 4;
    repeat (count) begin
      r   = $urandom_range(0, 99);
      cmd = CMD_PUT;
      ch  = 8'($urandom_range(0, 255));
      row = 5'($urandom_range(0, 31));
      col = 7'($urandom_range(0, 127));
      if (!scrolling && r < 3) begin
        cmd = CMD_CLEAR;
      end else if (r < 4) begin
        cmd = CMD_UNUSED;
      end else if (r < 34) begin
        cmd = CMD_READ;
        if ($urandom_range(0, 6) != 0) begin
          row = 5'($urandom_range(0, ROWS - 1));
          col = 7'($urandom_range(0, COLUMNS - 1));
        end
      end else begin
        k = $urandom_range(0, 99);
        if (k < lf_pct) ch = CH_LF;
        else if (k < lf_pct + 6) ch = CH_TAB;
        else if (k < lf_pct + 9) ch = CH_BS;
        else if (k < lf_pct + 11) ch = CH_CR;
      end
      send_item(cmd, ch, row, col);
    end
  endtask

  // output stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(LIMIT * 8);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send_item(CMD_READ,   8'h00, 5'd0,  7'd0);
    send_item(CMD_PUT,    8'h41, 5'd0,  7'd0);
    send_item(CMD_PUT,    8'h00, 5'd31, 7'd127);
    send_item(CMD_PUT,    8'hFF, 5'd0,  7'd0);
    send_item(CMD_PUT,    CH_TAB, 5'd0, 7'd0);
    send_item(CMD_PUT,    CH_BS, 5'd0,  7'd0);
    send_item(CMD_PUT,    CH_CR, 5'd0,  7'd0);
    send_item(CMD_PUT,    CH_BS, 5'd0,  7'd0);
    send_item(CMD_PUT,    CH_LF, 5'd0,  7'd0);
    send_item(CMD_READ,   8'hFF, 5'd0,  7'd0);
    send_item(CMD_READ,   8'h00, 5'd0,  7'd2);
    send_item(CMD_UNUSED, 8'hA5, 5'd3,  7'd5);
    send_item(CMD_READ,   8'h00, 5'd24, 7'd79);
    send_item(CMD_READ,   8'h00, 5'd25, 7'd0);
    send_item(CMD_READ,   8'h00, 5'd0,  7'd80);
    send_item(CMD_READ,   8'h00, 5'd31, 7'd127);
    send_item(CMD_PUT,    8'h7F, 5'd0,  7'd0);
    send_item(CMD_READ,   8'h00, 5'd1,  7'd0);
    send_item(CMD_CLEAR,  8'h00, 5'd0,  7'd0);
    send_item(CMD_READ,   8'h00, 5'd0,  7'd1);
    send_item(CMD_PUT,    CH_SPACE, 5'd0, 7'd0);

    write_attr(8'h00);
    random_phase(300, 1'b0);
    write_attr(8'hFF);
    random_phase(400, 1'b1);
    write_attr(8'($urandom_range(0, 255)));
    random_phase(300, 1'b0);
    write_attr(8'h1E);
    random_phase(250, 1'b1);
    write_attr(8'($urandom_range(0, 255)));
    calm = 1'b1;
    random_phase(300, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_character_writer_unit.sv
rtl/tcw_checker.sv
test/console_cursor_checker.sv
test/tb_text_console_character_writer_unit.sv
